FILE: rtl/core/lbl_ovl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbl_ovl_pkg
// shared types and constants for the label overlap checker
// ----------------------------------------------------------------------------
package lbl_ovl_pkg;

    localparam int AREA_W     = 24;
    localparam int AREA_SHIFT = 2;    // area divided by 4
    localparam int LIM_W      = AREA_W - AREA_SHIFT;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_CHECK = 2'd1;
    localparam logic [1:0] MODE_ADD   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic walk;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
    } ctrl_sts_t;

endpackage

FILE: rtl/core/lbl_ovl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbl_ovl_ctrl
// controller: takes a word, runs the list walk for checks, strobes the result
// ----------------------------------------------------------------------------
module lbl_ovl_ctrl
    import lbl_ovl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (mode == MODE_CHECK) ? ST_WALK : ST_RESP;
                end
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        done       = 1'b0;
        cmd.accept = 1'b0;
        cmd.walk   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/lbl_ovl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbl_ovl_dp
// datapath: label memory, count, and the pipelined distance compare
// ----------------------------------------------------------------------------
module lbl_ovl_dp
    import lbl_ovl_pkg::*;
#(
    parameter int MAX_LABELS = 256,
    parameter int COORD_BITS = 12
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ctrl_cmd_t                           cmd,
    output ctrl_sts_t                           sts,
    input  logic [1:0]                          mode,
    input  logic [COORD_BITS-1:0]               center_x,
    input  logic [COORD_BITS-1:0]               center_y,
    input  logic [AREA_W-1:0]                   pixel_area,
    output logic                                independent,
    output logic                                dropped,
    output logic [$clog2(MAX_LABELS+1)-1:0]     stored_count
);

    localparam int CNT_W   = $clog2(MAX_LABELS + 1);
    localparam int IDX_W   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int ENTRY_W = 2 * COORD_BITS + AREA_W;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = ((SQ_W + 1) > LIM_W) ? (SQ_W + 1) : LIM_W;

    logic [ENTRY_W-1:0] mem [MAX_LABELS];

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [COORD_BITS-1:0] qx_reg;
    logic [COORD_BITS-1:0] qy_reg;
    logic                  is_check_reg;
    logic                  drop_reg;
    logic                  hit_reg;
    logic                  hit_next;

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [LIM_W-1:0]      lim2_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    logic [LIM_W-1:0]      lim3_reg;

    logic                  full;
    logic                  do_add;
    logic                  issue;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [AREA_W-1:0]     ea;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DIST_W-1:0]     dist_sum;

    assign full   = (count_reg == CNT_W'(MAX_LABELS));
    assign do_add = cmd.accept && (mode == MODE_ADD) && !full;
    assign issue  = cmd.walk && (idx_reg < count_reg);

    assign ex = rd_data_reg[ENTRY_W-1 -: COORD_BITS];
    assign ey = rd_data_reg[AREA_W +: COORD_BITS];
    assign ea = rd_data_reg[AREA_W-1:0];
    assign dx = (qx_reg >= ex) ? (qx_reg - ex) : (ex - qx_reg);
    assign dy = (qy_reg >= ey) ? (qy_reg - ey) : (ey - qy_reg);
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    // memory: one write port for adds, one registered read port for the walk
    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            mem[count_reg[IDX_W-1:0]] <= {center_x, center_y, pixel_area};
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        if (cmd.accept)
        begin
            if (mode == MODE_CLEAR)
            begin
                count_next = '0;
            end
            else if (do_add)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            idx_next = '0;
            hit_next = 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (v3_reg && (dist_sum < DIST_W'(lim3_reg)))
            begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            is_check_reg <= 1'b0;
            drop_reg     <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (cmd.accept)
            begin
                is_check_reg <= (mode == MODE_CHECK);
                drop_reg     <= (mode == MODE_ADD) && full;
            end
        end
    end

    // query word and compare pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qx_reg <= center_x;
            qy_reg <= center_y;
        end
        dx_reg   <= dx;
        dy_reg   <= dy;
        lim2_reg <= ea[AREA_W-1:AREA_SHIFT];
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
        lim3_reg <= lim2_reg;
    end

    assign sts.walk_done = (idx_reg == count_reg) && !v1_reg && !v2_reg && !v3_reg;

    assign independent  = is_check_reg && !hit_reg;
    assign dropped      = drop_reg;
    assign stored_count = count_reg;

endmodule

FILE: rtl/core/label_overlap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_overlap_checker
// keeps a list of blob labels and checks new labels against it
// ----------------------------------------------------------------------------
// usage:
//   a word (mode, center_x, center_y, pixel_area) is taken at a clock edge
//   with start high and busy low. mode clear empties the list, add appends
//   the label (dropped is set when the list is full), check reports
//   independent unless the squared centroid distance to some stored label is
//   below that label's area / 4.
//   exactly one result per word: independent, dropped and stored_count are
//   valid during the single cycle in which done is high.
// sequencing:
//   clear, add and the unused mode: done is high in the cycle after the word is
//   taken, and busy stays high while done is, so the next word waits for done.
//   check: the walk reads one stored entry per cycle from the single read port
//   of the label memory, then drains a three-stage distance compare pipeline
//   before done is raised.
// reset: asynchronous, empties the list; memory contents are not cleared.
// the receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module label_overlap_checker
    import lbl_ovl_pkg::*;
#(
    parameter int MAX_LABELS = 256,
    parameter int COORD_BITS = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    output logic                            done,
    input  logic [1:0]                      mode,
    input  logic [COORD_BITS-1:0]           center_x,
    input  logic [COORD_BITS-1:0]           center_y,
    input  logic [AREA_W-1:0]               pixel_area,
    output logic                            independent,
    output logic                            dropped,
    output logic [$clog2(MAX_LABELS+1)-1:0] stored_count
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    lbl_ovl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    lbl_ovl_dp #(
        .MAX_LABELS (MAX_LABELS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .center_x     (center_x),
        .center_y     (center_y),
        .pixel_area   (pixel_area),
        .independent  (independent),
        .dropped      (dropped),
        .stored_count (stored_count)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for label_overlap_checker: a directed table covering
// the empty list, distance boundaries, area truncation and the unused mode,
// then random clear/add/check/unused traffic that fills the list to overflow.
// typed rows are checked against the table, all else against a local model.
// ----------------------------------------------------------------------------
module tb;
    import lbl_ovl_pkg::*;

    localparam int         COORD_W      = 12;
    localparam int         LIST_DEPTH   = 256;
    localparam int         COUNT_W      = $clog2(LIST_DEPTH + 1);
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         FILL_WORDS   = 400;
    localparam int         RANDOM_WORDS = 700;
    localparam int         DRAIN_CYCLES = 300;
    localparam int         STALL_LIMIT  = 4000;

    typedef struct packed {
        logic               independent;
        logic               dropped;
        logic [COUNT_W-1:0] stored_count;
    } label_result_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [AREA_W-1:0]  area;
        logic               typed;
        logic               independent;
        logic               dropped;
        logic [COUNT_W-1:0] stored_count;
    } label_row_t;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic [1:0]         mode         = MODE_CLEAR;
    logic [COORD_W-1:0] center_x     = '0;
    logic [COORD_W-1:0] center_y     = '0;
    logic [AREA_W-1:0]  pixel_area   = '0;
    logic               busy;
    logic               done;
    logic               independent;
    logic               dropped;
    logic [COUNT_W-1:0] stored_count;

    // local copy of the label list
    logic [COORD_W-1:0] lbl_x    [LIST_DEPTH];
    logic [COORD_W-1:0] lbl_y    [LIST_DEPTH];
    logic [AREA_W-1:0]  lbl_area [LIST_DEPTH];
    int                 lbl_count = 0;

    label_result_t      pending_results[$];
    int                 mismatches   = 0;
    int                 stall_cycles = 0;
    bit                 gapless      = 1'b0;

    label_row_t directed_rows [24] = '{
        '{MODE_CHECK,  12'd0,    12'd0,    24'd0,        1'b1, 1'b1, 1'b0, 9'd0},
        '{MODE_UNUSED, 12'hfff,  12'hfff,  24'hffffff,   1'b1, 1'b0, 1'b0, 9'd0},
        '{MODE_CLEAR,  12'hfff,  12'hfff,  24'hffffff,   1'b1, 1'b0, 1'b0, 9'd0},
        '{MODE_ADD,    12'd0,    12'd0,    24'hffffff,   1'b1, 1'b0, 1'b0, 9'd1},
        '{MODE_CHECK,  12'd0,    12'd0,    24'hffffff,   1'b1, 1'b0, 1'b0, 9'd1},
        '{MODE_CHECK,  12'hfff,  12'hfff,  24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_ADD,    12'hfff,  12'hfff,  24'd0,        1'b1, 1'b0, 1'b0, 9'd2},
        '{MODE_CHECK,  12'hfff,  12'hfff,  24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_ADD,    12'd100,  12'd100,  24'd4,        1'b1, 1'b0, 1'b0, 9'd3},
        '{MODE_CHECK,  12'd100,  12'd100,  24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_CHECK,  12'd101,  12'd100,  24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_ADD,    12'd800,  12'd800,  24'd403,      1'b1, 1'b0, 1'b0, 9'd4},
        '{MODE_CHECK,  12'd810,  12'd800,  24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_CHECK,  12'd809,  12'd804,  24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_UNUSED, 12'd1,    12'd2,    24'd3,        1'b1, 1'b0, 1'b0, 9'd4},
        '{MODE_CLEAR,  12'd0,    12'd0,    24'd0,        1'b1, 1'b0, 1'b0, 9'd0},
        '{MODE_CHECK,  12'hfff,  12'hfff,  24'hffffff,   1'b1, 1'b1, 1'b0, 9'd0},
        '{MODE_ADD,    12'd2048, 12'd2048, 24'd3,        1'b1, 1'b0, 1'b0, 9'd1},
        '{MODE_CHECK,  12'd2048, 12'd2048, 24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_ADD,    12'hfff,  12'd0,    24'hffffff,   1'b1, 1'b0, 1'b0, 9'd2},
        '{MODE_CHECK,  12'd0,    12'd0,    24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_CHECK,  12'hfff,  12'd2047, 24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_CHECK,  12'hfff,  12'd2048, 24'd0,        1'b0, 1'b0, 1'b0, 9'd0},
        '{MODE_CLEAR,  12'h5a5,  12'ha5a,  24'h123456,   1'b1, 1'b0, 1'b0, 9'd0}
    };

    label_overlap_checker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .mode         (mode),
        .center_x     (center_x),
        .center_y     (center_y),
        .pixel_area   (pixel_area),
        .independent  (independent),
        .dropped      (dropped),
        .stored_count (stored_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // applies one word to the label list and returns its result
    function automatic label_result_t apply_label_word(label_row_t r);
        label_result_t res;
        int unsigned   dx;
        int unsigned   dy;
        res = '0;
        if (r.mode == MODE_CLEAR)
        begin
            lbl_count = 0;
        end
        else if (r.mode == MODE_CHECK)
        begin
            res.independent = 1'b1;
            for (int i = 0; i < lbl_count; i++)
            begin
                dx = 32'((r.x >= lbl_x[i]) ? r.x - lbl_x[i] : lbl_x[i] - r.x);
                dy = 32'((r.y >= lbl_y[i]) ? r.y - lbl_y[i] : lbl_y[i] - r.y);
                if (dx * dx + dy * dy < 32'(lbl_area[i] >> AREA_SHIFT))
                    res.independent = 1'b0;
            end
        end
        else if (r.mode == MODE_ADD)
        begin
            if (lbl_count >= LIST_DEPTH)
            begin
                res.dropped = 1'b1;
            end
            else
            begin
                lbl_x[lbl_count]    = r.x;
                lbl_y[lbl_count]    = r.y;
                lbl_area[lbl_count] = r.area;
                lbl_count++;
            end
        end
        res.stored_count = COUNT_W'(lbl_count);
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] jitter(logic [COORD_W-1:0] c);
        int v;
        v = $urandom_range(0, 64);
        v = v + int'(c) - 32;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return COORD_W'(v);
    endfunction

    // sender gap, with occasional stretches of back-to-back words
    function automatic int draw_gap();
        if ($urandom_range(0, 39) == 0)
            gapless = ~gapless;
        return gapless ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic label_row_t make_random_word(bit filling);
        label_row_t  r;
        int unsigned pick;
        int          k;
        r    = '0;
        pick = $urandom_range(0, 99);
        if (filling)
            r.mode = (pick < 80) ? MODE_ADD : MODE_CHECK;
        else if (pick < 3)
            r.mode = MODE_CLEAR;
        else if (pick < 6)
            r.mode = MODE_UNUSED;
        else if (pick < 50)
            r.mode = MODE_ADD;
        else
            r.mode = MODE_CHECK;
        r.x = COORD_W'($urandom_range(0, 4095));
        r.y = COORD_W'($urandom_range(0, 4095));
        // aim half the checks at a stored label
        if (r.mode == MODE_CHECK && lbl_count != 0 && $urandom_range(0, 1) == 1)
        begin
            k   = $urandom_range(0, lbl_count - 1);
            r.x = jitter(lbl_x[k]);
            r.y = jitter(lbl_y[k]);
        end
        case ($urandom_range(0, 3))
            0:       r.area = AREA_W'($urandom_range(0, 64));
            1:       r.area = AREA_W'($urandom_range(0, 40000));
            2:       r.area = AREA_W'($urandom_range(0, 2000000));
            default: r.area = AREA_W'($urandom_range(0, 24'hffffff));
        endcase
        return r;
    endfunction

    task automatic send_word(input int gap, input label_row_t r);
        label_result_t res;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= r.mode;
        center_x   <= r.x;
        center_y   <= r.y;
        pixel_area <= r.area;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = apply_label_word(r);
        if (r.typed)
            res = '{r.independent, r.dropped, r.stored_count};
        pending_results.push_back(res);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_word(draw_gap(), directed_rows[i]);
        // first stretch has no clears so the list fills up and overflows
        for (int n = 0; n < RANDOM_WORDS; n++)
            send_word(draw_gap(), make_random_word(n < FILL_WORDS));
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        label_result_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;

            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got %0b/%0b/%0d",
                             $time, independent, dropped, stored_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (independent !== want.independent)
                    begin
                        mismatches++;
                        $display("%0t: independent mismatch: expected %0b, got %0b",
                                 $time, want.independent, independent);
                    end
                    if (dropped !== want.dropped)
                    begin
                        mismatches++;
                        $display("%0t: dropped mismatch: expected %0b, got %0b",
                                 $time, want.dropped, dropped);
                    end
                    if (stored_count !== want.stored_count)
                    begin
                        mismatches++;
                        $display("%0t: stored_count mismatch: expected %0d, got %0d",
                                 $time, want.stored_count, stored_count);
                    end
                end
            end
        end
    end

endmodule
